[rtl/cilp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_pkg: shared types and helpers for the C integer literal parser
// Phase and code enums, the per-literal summary passed from the character
// front end to the type ladder, and small character and width helpers.
// ----------------------------------------------------------------------------
package cilp_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration reset values
  localparam logic [CFG_W-1:0] INT_WIDTH_RST  = 7'd32;
  localparam logic [CFG_W-1:0] LONG_WIDTH_RST = 7'd64;
  localparam logic [CFG_W-1:0] LLONG_WIDTH_RST = 7'd64;

  typedef enum logic [1:0] {
    CFG_INT_WIDTH   = 2'd0,
    CFG_LONG_WIDTH  = 2'd1,
    CFG_LLONG_WIDTH = 2'd2,
    CFG_C89_MODE    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_NEED   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_SUFFIX = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2,
    BASE_BIN = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_LOWER = 2'd1,
    PEND_UPPER = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIGIT  = 2'd1,
    ERR_SUFFIX = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    TY_INT    = 3'd0,
    TY_UINT   = 3'd1,
    TY_LONG   = 3'd2,
    TY_ULONG  = 3'd3,
    TY_LLONG  = 3'd4,
    TY_ULLONG = 3'd5
  } type_code_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_DIGIT     = 3'd1,
    ST_BAD_SUFFIX    = 3'd2,
    ST_TOO_LARGE     = 3'd3,
    ST_MADE_UNSIGNED = 3'd4
  } status_t;

  // ASCII codes
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_LL = 8'h6c;
  localparam logic [7:0] CH_UL = 8'h4c;

  localparam logic [4:0] NOT_DIGIT = 5'd16;

  // one finished literal, handed from the front end to the ladder
  typedef struct packed {
    logic [VALUE_W-1:0] accum;
    logic               overflowed;
    logic               seen_unsigned;
    logic [1:0]         long_count;
    err_t               err;
    logic               saw_binary;
    logic               dec;
  } lit_t;

  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = NOT_DIGIT;
    if (c inside {[CH_0:CH_9]}) begin
      d = 5'(c - CH_0);
    end else if (hex && (c inside {[CH_LA:CH_LF]})) begin
      d = 5'(c - CH_LA + 8'd10);
    end else if (hex && (c inside {[CH_UA:CH_UF]})) begin
      d = 5'(c - CH_UA + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [4:0] base_val(input base_t b);
    logic [4:0] v;
    case (b)
      BASE_DEC: v = 5'd10;
      BASE_OCT: v = 5'd8;
      BASE_HEX: v = 5'd16;
      BASE_BIN: v = 5'd2;
      default:  v = 5'd10;
    endcase
    return v;
  endfunction

  // width 0 acts as 1, anything above 64 acts as 64
  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] e;
    if (w == '0) begin
      e = CFG_W'(1);
    end else if (w > CFG_W'(VALUE_W)) begin
      e = CFG_W'(VALUE_W);
    end else begin
      e = w;
    end
    return e;
  endfunction

  // n low ones, n in 0..64
  function automatic logic [VALUE_W-1:0] ones_mask(input logic [CFG_W-1:0] n);
    logic [VALUE_W-1:0] m;
    for (int i = 0; i < VALUE_W; i++) begin
      m[i] = (CFG_W'(i) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/cilp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_front: character front end
// Tracks prefix, digit and suffix phases, accumulates the value by base and
// pushes a literal summary on the last character.
// ----------------------------------------------------------------------------
module cilp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    ch,
  input  wire logic          last,
  output cilp_pkg::lit_t     push_data,
  output logic               push
);

  cilp_pkg::phase_t                 phase, phase_next;
  cilp_pkg::base_t                  base_code, base_code_next;
  logic [cilp_pkg::VALUE_W-1:0]     accum, accum_next;
  logic                             overflowed, overflowed_next;
  logic                             seen_unsigned, seen_unsigned_next;
  logic [1:0]                       long_count, long_count_next;
  cilp_pkg::pend_t                  pending, pending_next;
  cilp_pkg::err_t                   err, err_next;
  logic                             saw_binary, saw_binary_next;

  logic [4:0]                       d;
  logic                             is_dig;
  logic                             too_big;
  logic                             is_l;
  logic                             is_u;
  logic                             do_add;
  logic                             do_sfx;
  logic [cilp_pkg::VALUE_W+3:0]     mac;
  logic [1:0]                       sfx_lc;

  assign d       = cilp_pkg::digit_val(ch, base_code == cilp_pkg::BASE_HEX);
  assign is_dig  = (d != cilp_pkg::NOT_DIGIT);
  assign too_big = (d >= cilp_pkg::base_val(base_code));
  assign is_l    = (ch == cilp_pkg::CH_LL) || (ch == cilp_pkg::CH_UL);
  assign is_u    = (ch == cilp_pkg::CH_LU) || (ch == cilp_pkg::CH_UU);

  // accum * base + digit, carry-out above bit 63 marks a wrap
  always_comb begin
    case (base_code)
      cilp_pkg::BASE_DEC: mac = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0};
      cilp_pkg::BASE_OCT: mac = {1'b0, accum, 3'b000};
      cilp_pkg::BASE_HEX: mac = {accum, 4'b0000};
      cilp_pkg::BASE_BIN: mac = {3'b000, accum, 1'b0};
      default:            mac = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0};
    endcase
    mac = mac + (cilp_pkg::VALUE_W + 4)'(d);
  end

  // next state
  always_comb begin
    phase_next         = phase;
    base_code_next     = base_code;
    accum_next         = accum;
    overflowed_next    = overflowed;
    seen_unsigned_next = seen_unsigned;
    long_count_next    = long_count;
    pending_next       = pending;
    err_next           = err;
    saw_binary_next    = saw_binary;
    do_add             = 1'b0;
    do_sfx             = 1'b0;
    sfx_lc             = long_count;

    if (err == cilp_pkg::ERR_NONE) begin
      case (phase)
        cilp_pkg::PH_FIRST: begin
          if ((ch == cilp_pkg::CH_0) && !last) begin
            base_code_next = cilp_pkg::BASE_OCT;
            phase_next     = cilp_pkg::PH_ZERO;
          end else if (!is_dig) begin
            err_next = cilp_pkg::ERR_DIGIT;
          end else begin
            do_add     = 1'b1;
            phase_next = cilp_pkg::PH_DIGITS;
          end
        end
        cilp_pkg::PH_ZERO: begin
          if (((ch == cilp_pkg::CH_LX) || (ch == cilp_pkg::CH_UX)) && !last) begin
            base_code_next = cilp_pkg::BASE_HEX;
            phase_next     = cilp_pkg::PH_NEED;
          end else if (((ch == cilp_pkg::CH_LB) || (ch == cilp_pkg::CH_UB)) && !last) begin
            base_code_next  = cilp_pkg::BASE_BIN;
            saw_binary_next = 1'b1;
            phase_next      = cilp_pkg::PH_NEED;
          end else if (is_dig) begin
            phase_next = cilp_pkg::PH_DIGITS;
            if (too_big) begin
              err_next = cilp_pkg::ERR_DIGIT;
            end else begin
              do_add = 1'b1;
            end
          end else begin
            phase_next = cilp_pkg::PH_SUFFIX;
            do_sfx     = 1'b1;
          end
        end
        cilp_pkg::PH_NEED: begin
          phase_next = cilp_pkg::PH_DIGITS;
          if (!is_dig || too_big) begin
            err_next = cilp_pkg::ERR_DIGIT;
          end else begin
            do_add = 1'b1;
          end
        end
        cilp_pkg::PH_DIGITS: begin
          if (is_dig) begin
            if (too_big) begin
              err_next = cilp_pkg::ERR_DIGIT;
            end else begin
              do_add = 1'b1;
            end
          end else begin
            phase_next = cilp_pkg::PH_SUFFIX;
            do_sfx     = 1'b1;
          end
        end
        cilp_pkg::PH_SUFFIX: begin
          do_sfx = 1'b1;
        end
        default: begin
          phase_next = cilp_pkg::PH_FIRST;
        end
      endcase
    end

    if (do_add) begin
      accum_next = mac[cilp_pkg::VALUE_W-1:0];
      if (mac[cilp_pkg::VALUE_W+3:cilp_pkg::VALUE_W] != 4'd0) begin
        overflowed_next = 1'b1;
      end
    end

    // u / l / ll suffix; a pending l either pairs up or settles as one l
    if (do_sfx) begin
      if ((pending != cilp_pkg::PEND_NONE) && is_l) begin
        if ((ch == cilp_pkg::CH_UL) == (pending == cilp_pkg::PEND_UPPER)) begin
          long_count_next = 2'd2;
          pending_next    = cilp_pkg::PEND_NONE;
        end else begin
          err_next = cilp_pkg::ERR_SUFFIX;
        end
      end else begin
        if (pending != cilp_pkg::PEND_NONE) begin
          sfx_lc          = 2'd1;
          long_count_next = 2'd1;
          pending_next    = cilp_pkg::PEND_NONE;
        end
        if (is_u && !seen_unsigned) begin
          seen_unsigned_next = 1'b1;
        end else if (is_l && (sfx_lc == 2'd0)) begin
          pending_next = (ch == cilp_pkg::CH_UL) ? cilp_pkg::PEND_UPPER
                                                 : cilp_pkg::PEND_LOWER;
        end else begin
          err_next = cilp_pkg::ERR_SUFFIX;
        end
      end
    end
  end

  // summary outputs
  always_comb begin
    push                    = accept && last;
    push_data.accum         = accum_next;
    push_data.overflowed    = overflowed_next;
    push_data.seen_unsigned = seen_unsigned_next;
    push_data.long_count    = long_count_next;
    if ((err_next == cilp_pkg::ERR_NONE) && (pending_next != cilp_pkg::PEND_NONE)) begin
      push_data.long_count = 2'd1;
    end
    push_data.err        = err_next;
    push_data.saw_binary = saw_binary_next;
    push_data.dec        = (base_code_next == cilp_pkg::BASE_DEC);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase         <= cilp_pkg::PH_FIRST;
      base_code     <= cilp_pkg::BASE_DEC;
      accum         <= '0;
      overflowed    <= 1'b0;
      seen_unsigned <= 1'b0;
      long_count    <= 2'd0;
      pending       <= cilp_pkg::PEND_NONE;
      err           <= cilp_pkg::ERR_NONE;
      saw_binary    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      base_code     <= base_code_next;
      accum         <= accum_next;
      overflowed    <= overflowed_next;
      seen_unsigned <= seen_unsigned_next;
      long_count    <= long_count_next;
      pending       <= pending_next;
      err           <= err_next;
      saw_binary    <= saw_binary_next;
    end
  end

endmodule
`default_nettype wire

[rtl/cilp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_queue: literal summary queue
// Small register queue that decouples the character front end from the
// type ladder and output register.
// ----------------------------------------------------------------------------
module cilp_queue #(
  parameter int unsigned DEPTH = cilp_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cilp_pkg::lit_t push_data,
  output logic                has_space,
  input  wire logic           pop,
  output logic                head_valid,
  output cilp_pkg::lit_t      head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cilp_pkg::lit_t     entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign has_space  = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && has_space;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cilp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_back: type ladder and result register
// Holds the width configuration, picks the C type and status for the
// literal at the queue head and registers the result for the output side.
// ----------------------------------------------------------------------------
module cilp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [cilp_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         head_valid,
  input  wire cilp_pkg::lit_t               head,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [71:0]                       m_axis_tdata
);

  logic [cilp_pkg::CFG_W-1:0]   int_width;
  logic [cilp_pkg::CFG_W-1:0]   long_width;
  logic [cilp_pkg::CFG_W-1:0]   long_long_width;
  logic                         c89_mode;

  logic [cilp_pkg::CFG_W-1:0]   e_int;
  logic [cilp_pkg::CFG_W-1:0]   e_long;
  logic [cilp_pkg::CFG_W-1:0]   e_llong;
  logic                         fu_int, fs_int, fu_long, fs_long, fs_llong;

  cilp_pkg::type_code_t         ty;
  logic                         big;
  cilp_pkg::type_code_t         res_type;
  cilp_pkg::status_t            res_status;
  logic [cilp_pkg::VALUE_W-1:0] res_value;

  logic [cilp_pkg::VALUE_W-1:0] value;
  cilp_pkg::type_code_t         type_code;
  cilp_pkg::status_t            status;
  logic                         binary_prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_width       <= cilp_pkg::INT_WIDTH_RST;
      long_width      <= cilp_pkg::LONG_WIDTH_RST;
      long_long_width <= cilp_pkg::LLONG_WIDTH_RST;
      c89_mode        <= 1'b0;
    end else if (cfg_valid) begin
      case (cilp_pkg::cfg_index_t'(cfg_index))
        cilp_pkg::CFG_INT_WIDTH:   int_width       <= cfg_data;
        cilp_pkg::CFG_LONG_WIDTH:  long_width      <= cfg_data;
        cilp_pkg::CFG_LLONG_WIDTH: long_long_width <= cfg_data;
        cilp_pkg::CFG_C89_MODE:    c89_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // fit tests: no bit set at or above the width (width - 1 when signed)
  always_comb begin
    e_int    = cilp_pkg::eff_width(int_width);
    e_long   = cilp_pkg::eff_width(long_width);
    e_llong  = cilp_pkg::eff_width(long_long_width);
    fu_int   = ((head.accum & ~cilp_pkg::ones_mask(e_int)) == '0);
    fs_int   = ((head.accum & ~cilp_pkg::ones_mask(e_int - 7'd1)) == '0);
    fu_long  = ((head.accum & ~cilp_pkg::ones_mask(e_long)) == '0);
    fs_long  = ((head.accum & ~cilp_pkg::ones_mask(e_long - 7'd1)) == '0);
    fs_llong = ((head.accum & ~cilp_pkg::ones_mask(e_llong - 7'd1)) == '0);
  end

  // promotion ladder; decimals skip unsigned rungs
  always_comb begin
    big = 1'b0;
    ty  = cilp_pkg::TY_ULLONG;
    if (head.seen_unsigned) begin
      if (head.long_count == 2'd2) begin
        ty = cilp_pkg::TY_ULLONG;
      end else if (head.long_count == 2'd1) begin
        ty = fu_long ? cilp_pkg::TY_ULONG : cilp_pkg::TY_ULLONG;
      end else if (fu_int) begin
        ty = cilp_pkg::TY_UINT;
      end else begin
        ty = fu_long ? cilp_pkg::TY_ULONG : cilp_pkg::TY_ULLONG;
      end
    end else if (head.long_count == 2'd2) begin
      if (fs_llong) begin
        ty = cilp_pkg::TY_LLONG;
      end else begin
        big = head.dec;
      end
    end else if (head.long_count == 2'd1) begin
      if (fs_long) begin
        ty = cilp_pkg::TY_LONG;
      end else if (!head.dec && fu_long) begin
        ty = cilp_pkg::TY_ULONG;
      end else if (fs_llong) begin
        ty = cilp_pkg::TY_LLONG;
      end else begin
        big = head.dec;
      end
    end else if (fs_int) begin
      ty = cilp_pkg::TY_INT;
    end else if (!head.dec && fu_int) begin
      ty = cilp_pkg::TY_UINT;
    end else if (fs_long) begin
      ty = cilp_pkg::TY_LONG;
    end else if (!head.dec && fu_long) begin
      ty = cilp_pkg::TY_ULONG;
    end else if (head.dec && c89_mode) begin
      if (fu_long) begin
        ty = cilp_pkg::TY_ULONG;
      end else begin
        big = 1'b1;
      end
    end else if (fs_llong) begin
      ty = cilp_pkg::TY_LLONG;
    end else begin
      big = head.dec;
    end
  end

  // errors outrank overflow, overflow outranks the ladder
  always_comb begin
    res_value  = head.accum;
    res_type   = ty;
    res_status = big ? cilp_pkg::ST_MADE_UNSIGNED : cilp_pkg::ST_OK;
    case (head.err)
      cilp_pkg::ERR_DIGIT: begin
        res_value  = '0;
        res_type   = cilp_pkg::TY_INT;
        res_status = cilp_pkg::ST_BAD_DIGIT;
      end
      cilp_pkg::ERR_SUFFIX: begin
        res_value  = '0;
        res_type   = cilp_pkg::TY_INT;
        res_status = cilp_pkg::ST_BAD_SUFFIX;
      end
      default: begin
        if (head.overflowed) begin
          res_type   = cilp_pkg::TY_ULLONG;
          res_status = cilp_pkg::ST_TOO_LARGE;
        end
      end
    endcase
  end

  assign pop = head_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value         <= res_value;
      type_code     <= res_type;
      status        <= res_status;
      binary_prefix <= head.saw_binary;
    end
  end

  assign m_axis_tdata = {1'b0, binary_prefix, status, type_code, value};

endmodule
`default_nettype wire

[rtl/c_integer_literal_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c_integer_literal_parser_top: C integer literal parser
// Path: a result reaches m_axis through the summary queue and the result
//   register (the summary enters the queue at the transfer of the last
//   character, the result register loads when it leaves the queue head).
// Throughput: one character per cycle, sustained, including back-to-back
//   literals; the only stall is a full summary queue under output backpressure.
// Reset: rst (synchronous, active high) clears the parse state, empties the
//   queue and the result register, and loads widths 32/64/64 with C89 mode off.
// ----------------------------------------------------------------------------
module c_integer_literal_parser_top #(
  parameter int unsigned QUEUE_DEPTH = cilp_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  // character stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [7:0] ch
  input  wire logic                         s_axis_tlast,   // last character

  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [71:0]                       m_axis_tdata,   // [63:0] value,
                                                            // [66:64] type_code,
                                                            // [69:67] status,
                                                            // [70] binary_prefix,
                                                            // [71] zero

  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [cilp_pkg::CFG_W-1:0]   cfg_data
);

  // Front end: one character per transfer. It walks the prefix (0x, 0b, 0),
  // the digits and the u/l/ll suffix, and keeps the value modulo 2^64 with a
  // sticky wrap flag. On the last character it pushes one summary.
  logic            accept;
  logic            push;
  cilp_pkg::lit_t  push_data;

  // Queue between front end and ladder: lets the front end keep taking
  // characters while a finished result waits on the output side.
  logic            has_space;
  logic            pop;
  logic            head_valid;
  cilp_pkg::lit_t  head;

  // Configuration registers take every write at once; they only matter to the
  // ladder, which reads them when a summary leaves the queue.
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = has_space;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cilp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ch        (s_axis_tdata),
    .last      (s_axis_tlast),
    .push_data (push_data),
    .push      (push)
  );

  cilp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .has_space  (has_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: promotion ladder against the configured widths, error and
  // overflow priority, then the output register.
  cilp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[test/c_integer_literal_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// c_integer_literal_parser_top_tb: self-checking bench for the literal parser
// Streams C integer literal spellings one character per transfer, predicts
// value, type, status and the binary-prefix flag for every finished literal,
// and compares each result transfer against the oldest prediction. Runs a
// short directed set, then random literals under several width settings and
// idle patterns, including a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module c_integer_literal_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cilp_pkg::*;

  localparam int unsigned NO_DIGIT         = 16;
  localparam int unsigned DRAIN_CYCLES     = 4;    // settling time after the last predicted result
  localparam int unsigned DRAIN_GUARD      = 5000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  // one predicted result transfer
  typedef struct packed {
    logic [63:0] value;
    type_code_t  kind;
    status_t     status;
    logic        bin;
  } literal_result_t;

  logic clk;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] ch
  logic        s_axis_tlast  = 1'b0;   // last character of the literal

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // [63:0] value, [66:64] type_code,
                                       // [69:67] status, [70] binary_prefix, [71] zero

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_INT_WIDTH;
  logic [6:0]  cfg_data  = 7'd0;

  c_integer_literal_parser_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: a private copy of the width registers and the per-literal
  // scan state, advanced once per character handed to the block.
  // --------------------------------------------------------------------------
  logic [6:0]  cf_int   = INT_WIDTH_RST;
  logic [6:0]  cf_long  = LONG_WIDTH_RST;
  logic [6:0]  cf_llong = LLONG_WIDTH_RST;
  logic        cf_c89   = 1'b0;

  phase_t      lp_phase    = PH_FIRST;
  base_t       lp_base     = BASE_DEC;
  logic [63:0] lp_accum    = '0;
  logic        lp_wrapped  = 1'b0;
  logic        lp_unsigned = 1'b0;
  logic [1:0]  lp_longs    = 2'd0;
  pend_t       lp_pend     = PEND_NONE;
  err_t        lp_err      = ERR_NONE;
  logic        lp_bin      = 1'b0;

  literal_result_t expected_literals[$];

  int unsigned failures       = 0;
  int unsigned chars_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold      = 1'b0;
  event        start_long_hold;

  logic [7:0]  spelling[$];

  function automatic void start_new_literal();
    lp_phase    = PH_FIRST;
    lp_base     = BASE_DEC;
    lp_accum    = '0;
    lp_wrapped  = 1'b0;
    lp_unsigned = 1'b0;
    lp_longs    = 2'd0;
    lp_pend     = PEND_NONE;
    lp_err      = ERR_NONE;
    lp_bin      = 1'b0;
  endfunction

  function automatic int unsigned radix();
    case (lp_base)
      BASE_OCT: return 8;
      BASE_HEX: return 16;
      BASE_BIN: return 2;
      default:  return 10;
    endcase
  endfunction

  function automatic int unsigned char_digit(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return NO_DIGIT;
  endfunction

  // true when v is representable in a type of width w
  function automatic bit fits_in(logic [63:0] v, logic [6:0] w, bit sgn);
    int unsigned bits;
    bits = (w == 0) ? 1 : (w > 64) ? 64 : w;
    if (sgn) bits--;
    return (bits >= 64) || ((v >> bits) == 64'd0);
  endfunction

  function automatic void add_to_value(int unsigned d);
    logic [67:0] wide;
    wide = 68'(lp_accum) * 68'(radix()) + 68'(d);
    if (wide[67:64] != 4'd0) lp_wrapped = 1'b1;
    lp_accum = wide[63:0];
  endfunction

  // false when c is no digit at all; a digit beyond the base is an error
  function automatic bit take_digit(logic [7:0] c);
    int unsigned d;
    d = char_digit(c, lp_base == BASE_HEX);
    if (d == NO_DIGIT) return 1'b0;
    if (d >= radix()) lp_err = ERR_DIGIT;
    else add_to_value(d);
    return 1'b1;
  endfunction

  function automatic void take_suffix(logic [7:0] c);
    bit is_l;
    is_l = (c == "l" || c == "L");
    if (lp_pend != PEND_NONE) begin
      if (is_l) begin
        // the second l must match the case of the first
        if ((c == "L") == (lp_pend == PEND_UPPER)) begin
          lp_longs = 2'd2;
          lp_pend  = PEND_NONE;
        end else begin
          lp_err = ERR_SUFFIX;
        end
        return;
      end
      lp_longs = 2'd1;
      lp_pend  = PEND_NONE;
    end
    if ((c == "u" || c == "U") && !lp_unsigned) lp_unsigned = 1'b1;
    else if (is_l && lp_longs == 2'd0) lp_pend = (c == "L") ? PEND_UPPER : PEND_LOWER;
    else lp_err = ERR_SUFFIX;
  endfunction

  // promotion ladder; big flags a decimal forced into unsigned long long
  function automatic type_code_t choose_type(logic [63:0] v, output bit big);
    bit dec;
    dec = (lp_base == BASE_DEC);
    big = 1'b0;
    if (lp_unsigned) begin
      if (lp_longs == 2'd2) return TY_ULLONG;
      if (lp_longs == 2'd0 && fits_in(v, cf_int, 1'b0)) return TY_UINT;
      return fits_in(v, cf_long, 1'b0) ? TY_ULONG : TY_ULLONG;
    end
    if (lp_longs == 2'd2) begin
      if (fits_in(v, cf_llong, 1'b1)) return TY_LLONG;
      big = dec;
      return TY_ULLONG;
    end
    if (lp_longs == 2'd0) begin
      if (fits_in(v, cf_int, 1'b1)) return TY_INT;
      if (!dec && fits_in(v, cf_int, 1'b0)) return TY_UINT;
    end
    if (fits_in(v, cf_long, 1'b1)) return TY_LONG;
    if (!dec && fits_in(v, cf_long, 1'b0)) return TY_ULONG;
    if (lp_longs == 2'd0 && dec && cf_c89) begin
      if (fits_in(v, cf_long, 1'b0)) return TY_ULONG;
      big = 1'b1;
      return TY_ULLONG;
    end
    if (fits_in(v, cf_llong, 1'b1)) return TY_LLONG;
    big = dec;
    return TY_ULLONG;
  endfunction

  // advance the scan by one character; on the last one queue the result
  function automatic void scan_char(logic [7:0] c, logic lst);
    literal_result_t res;
    bit big;
    if (lp_err == ERR_NONE) begin
      case (lp_phase)
        PH_FIRST: begin
          if (c == "0" && !lst) begin
            lp_base  = BASE_OCT;
            lp_phase = PH_ZERO;
          end else if (char_digit(c, 1'b0) == NO_DIGIT) begin
            lp_err = ERR_DIGIT;
          end else begin
            add_to_value(char_digit(c, 1'b0));
            lp_phase = PH_DIGITS;
          end
        end
        PH_ZERO: begin
          if ((c == "x" || c == "X") && !lst) begin
            lp_base  = BASE_HEX;
            lp_phase = PH_NEED;
          end else if ((c == "b" || c == "B") && !lst) begin
            lp_base  = BASE_BIN;
            lp_bin   = 1'b1;
            lp_phase = PH_NEED;
          end else begin
            lp_phase = PH_DIGITS;
            if (!take_digit(c)) begin
              lp_phase = PH_SUFFIX;
              take_suffix(c);
            end
          end
        end
        PH_NEED: begin
          if (!take_digit(c)) lp_err = ERR_DIGIT;
          lp_phase = PH_DIGITS;
        end
        PH_DIGITS: begin
          if (!take_digit(c)) begin
            lp_phase = PH_SUFFIX;
            take_suffix(c);
          end
        end
        default: take_suffix(c);
      endcase
    end
    if (!lst) return;

    // a lone trailing l counts as long
    if (lp_err == ERR_NONE && lp_pend != PEND_NONE) begin
      lp_longs = 2'd1;
      lp_pend  = PEND_NONE;
    end

    res.value  = '0;
    res.kind   = TY_INT;
    res.status = ST_OK;
    res.bin    = lp_bin;
    if (lp_err != ERR_NONE) begin
      res.status = (lp_err == ERR_DIGIT) ? ST_BAD_DIGIT : ST_BAD_SUFFIX;
    end else if (lp_wrapped) begin
      res.value  = lp_accum;
      res.kind   = TY_ULLONG;
      res.status = ST_TOO_LARGE;
    end else begin
      res.value  = lp_accum;
      res.kind   = choose_type(lp_accum, big);
      res.status = big ? ST_MADE_UNSIGNED : ST_OK;
    end
    expected_literals.push_back(res);
    start_new_literal();
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one character; idle first at the sender's rate, then hold until
  // the transfer completes. Valid stays high for a following character.
  task automatic send_char(input logic [7:0] c, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= lst;
    scan_char(c, lst);
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
  endtask

  // send the whole spelling, last flag on its final character
  task automatic send_spelling();
    foreach (spelling[i]) send_char(spelling[i], i == spelling.size() - 1);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) spelling.push_back(s[i]);
  endtask

  // drop valid and wait for every predicted result, then let the pipe settle
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_literals.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller drops valid after its last write
  task automatic write_reg(input cfg_index_t idx, input logic [6:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INT_WIDTH:   cf_int   = d;
      CFG_LONG_WIDTH:  cf_long  = d;
      CFG_LLONG_WIDTH: cf_llong = d;
      default:         cf_c89   = d[0];
    endcase
  endtask

  task automatic set_widths(input logic [6:0] iw, input logic [6:0] lw,
                            input logic [6:0] llw, input logic c89);
    write_reg(CFG_INT_WIDTH, iw);
    write_reg(CFG_LONG_WIDTH, lw);
    write_reg(CFG_LLONG_WIDTH, llw);
    write_reg(CFG_C89_MODE, {6'd0, c89});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] numeral(int unsigned d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
  endfunction

  // Build one random spelling: mostly well formed with values near powers
  // of two, some overflowing, and a share of bad digits, bare prefixes,
  // broken suffixes and raw bytes.
  task automatic build_literal();
    string good_sfx [18] = '{"u", "U", "l", "L", "ll", "LL", "ul", "lu", "uL", "Lu",
                             "ull", "llu", "ULL", "LLU", "uLL", "LLu", "Ull", "llU"};
    string bad_sfx [12]  = '{"lL", "Ll", "uu", "lll", "LLL", "lul", "llL", "uLl",
                             "Uu", "llul", "z", "u."};
    int unsigned roll, pick, radix_n, k, n, d;
    logic [63:0] v;
    logic [7:0]  digits[$];
    base_t       b;

    spelling.delete();
    roll = $urandom_range(99);
    if (roll < 6) begin
      n = $urandom_range(1, 4);
      repeat (n) spelling.push_back(8'($urandom_range(255)));
      return;
    end

    pick = $urandom_range(99);
    if (pick < 35) begin
      b = BASE_DEC; radix_n = 10;
    end else if (pick < 65) begin
      b = BASE_HEX; radix_n = 16;
    end else if (pick < 85) begin
      b = BASE_OCT; radix_n = 8;
    end else begin
      b = BASE_BIN; radix_n = 2;
    end

    if (roll >= 20 && roll < 24 && b != BASE_DEC) begin
      // bare prefix, nothing after it
      spelling.push_back("0");
      spelling.push_back($urandom_range(1) ? (b == BASE_BIN ? "b" : "x")
                                           : (b == BASE_BIN ? "B" : "X"));
      return;
    end

    // value around a power of two
    k = (b == BASE_BIN && $urandom_range(3) != 0) ? $urandom_range(16) : $urandom_range(64);
    v = {$urandom, $urandom};
    if (k < 64) v &= (64'd1 << k) - 64'd1;
    case ($urandom_range(3))
      1: v = (64'd1 << k) - 64'd1;
      2: v = 64'd1 << k;
      3: v = (64'd1 << k) + 64'd1;
      default: ;
    endcase
    do begin
      d = v % radix_n;
      v = v / radix_n;
      digits.push_front(numeral(d));
    end while (v != 0);

    // long digit runs that can wrap past 64 bits
    if (roll >= 6 && roll < 14 && b != BASE_BIN) begin
      digits.delete();
      n = (b == BASE_DEC) ? $urandom_range(20, 24)
        : (b == BASE_HEX) ? $urandom_range(17, 19) : $urandom_range(22, 24);
      repeat (n) digits.push_back(numeral($urandom_range(radix_n - 1)));
      if (b == BASE_DEC && digits[0] == "0") digits[0] = "1";
    end

    // a digit the base does not allow
    if (roll >= 14 && roll < 20) begin
      n = $urandom_range(digits.size() - 1);
      case (b)
        BASE_OCT: digits[n] = $urandom_range(1) ? "8" : "9";
        BASE_BIN: digits[n] = 8'("2" + $urandom_range(7));
        BASE_HEX: digits[n] = $urandom_range(1) ? "g" : "G";
        default:  digits[n] = "a";
      endcase
    end

    case (b)
      BASE_OCT: spelling.push_back("0");
      BASE_HEX: begin
        spelling.push_back("0");
        spelling.push_back($urandom_range(1) ? "x" : "X");
      end
      BASE_BIN: begin
        spelling.push_back("0");
        spelling.push_back($urandom_range(1) ? "b" : "B");
      end
      default: ;
    endcase
    foreach (digits[i]) spelling.push_back(digits[i]);

    if (roll >= 24 && roll < 32) append_text(bad_sfx[$urandom_range(11)]);
    else if ($urandom_range(1)) append_text(good_sfx[$urandom_range(17)]);
  endtask

  // random literals until the character budget is used, then drain
  task automatic run_random(input int unsigned budget);
    int unsigned first;
    first = chars_sent;
    while (chars_sent - first < budget) begin
      build_literal();
      send_spelling();
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off counted in its own
  // process so the summary queue fills and the input stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_axis_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(start_long_hold);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  function automatic void report_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t ERROR %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    literal_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_literals.size() == 0) begin
        failures++;
        $display("%0t ERROR result: expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_literals.pop_front();
        report_field("value", want.value, m_axis_tdata[63:0]);
        report_field("type_code", want.kind, m_axis_tdata[66:64]);
        report_field("status", want.status, m_axis_tdata[69:67]);
        report_field("binary_prefix", want.bin, m_axis_tdata[70]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset widths; prefixes, bad digits, suffix errors, extreme bytes
  task automatic test_directed_cases();
    string cases [9] = '{"0x", "0b", "0xg", "08", "0b2", "1lLu", "2uu", "3lll", "0"};
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    foreach (cases[i]) begin
      spelling.delete();
      append_text(cases[i]);
      send_spelling();
    end
    spelling.delete();
    spelling.push_back(8'h00);
    send_spelling();
    spelling.delete();
    spelling.push_back(8'hff);
    send_spelling();
    wait_drained();
  endtask

  // full rate both ways at the reset widths
  task automatic test_back_to_back();
    set_widths(INT_WIDTH_RST, LONG_WIDTH_RST, LLONG_WIDTH_RST, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    run_random(450);
  endtask

  // narrow widths (8/16/32) with the C89 ladder, sender idling half the time
  task automatic test_sender_gaps();
    set_widths(7'd8, 7'd16, 7'd32, 1'b1);
    send_idle_pct  = 50;
    recv_stall_pct <= 0;
    run_random(380);
  endtask

  // 32-bit long with C89, receiver stalling half the time
  task automatic test_receiver_stalls();
    set_widths(7'd32, 7'd32, 7'd64, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct <= 50;
    run_random(380);
  endtask

  // all types 64 bits wide, both sides idling
  task automatic test_both_sides_idle();
    set_widths(7'd64, 7'd64, 7'd64, 1'b0);
    send_idle_pct  = 22;
    recv_stall_pct <= 22;
    run_random(380);
  endtask

  // widths outside the usual range, then fully random register values
  task automatic test_odd_widths();
    send_idle_pct  = 22;
    recv_stall_pct <= 22;
    set_widths(7'd0, 7'd127, 7'd65, 1'b1);
    run_random(90);
    set_widths(7'd1, 7'd0, 7'd127, 1'b0);
    run_random(90);
    repeat (2) begin
      set_widths(7'($urandom_range(127)), 7'($urandom_range(127)),
                 7'($urandom_range(127)), 1'($urandom_range(1)));
      run_random(60);
    end
  endtask

  // hold the result side off while short literals keep coming
  task automatic test_output_backpressure();
    set_widths(INT_WIDTH_RST, LONG_WIDTH_RST, LLONG_WIDTH_RST, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    @(posedge clk);
    -> start_long_hold;
    repeat (60) begin
      spelling.delete();
      spelling.push_back(8'("0" + $urandom_range(9)));
      if ($urandom_range(1)) spelling.push_back($urandom_range(1) ? "u" : "L");
      send_spelling();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_odd_widths();
    test_output_backpressure();
    wait_drained();

    if (expected_literals.size() != 0) begin
      failures++;
      $display("%0t ERROR results outstanding: expected 0, actual %0d", $time,
               expected_literals.size());
    end
    if (failures == 0) begin
      $display("PASS c_integer_literal_parser_top");
    end else begin
      $display("FAIL c_integer_literal_parser_top");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL c_integer_literal_parser_top");
    $finish;
  end

endmodule
